### hdl/ptst_pkg.sv
`timescale 1ns / 1ps

package ptst_pkg;

  // Number of timer slots held in the table.
  localparam int NUM_SLOTS = 16;

  // Width of a slot index inside the block.
  localparam int IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

  localparam int OP_W       = 2;
  localparam int SLOT_W     = 4;
  localparam int DEADLINE_W = 64;
  localparam int PERIOD_W   = 32;

  localparam logic [DEADLINE_W-1:0] DEADLINE_NONE = {DEADLINE_W{1'b1}};

  typedef enum logic [OP_W-1:0] {
    OP_ARM    = 2'd0,
    OP_CANCEL = 2'd1,
    OP_TICK   = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FINAL
  } state_e;

  // One entry of the slot store.
  typedef struct packed {
    logic [DEADLINE_W-1:0] deadline;
    logic [PERIOD_W-1:0]   period;
  } entry_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic arm;
    logic cancel;
    logic start;
    logic advance;
    logic emit_fired;
    logic emit_final;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic hit;
    logic last_idx;
    logic out_free;
  } stat_t;

endpackage

### hdl/ptst_ram.sv
`timescale 1ns / 1ps

module ptst_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### hdl/ptst_ctrl.sv
`timescale 1ns / 1ps

module ptst_ctrl import ptst_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  logic [OP_W-1:0] op_i,
  input  stat_t           stat_i,
  output cmd_t            cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          unique case (op_e'(op_i))
            OP_ARM:    cmd_o.arm    = 1'b1;
            OP_CANCEL: cmd_o.cancel = 1'b1;
            OP_TICK: begin
              cmd_o.start = 1'b1;
              state_d     = ST_SCAN;
            end
            default: ;
          endcase
        end
      end
      ST_SCAN: begin
        // A hit waits until the output register can take its result.
        if (!stat_i.hit || stat_i.out_free) begin
          cmd_o.advance    = 1'b1;
          cmd_o.emit_fired = stat_i.hit;
          if (stat_i.last_idx) begin
            state_d = ST_FINAL;
          end
        end
      end
      ST_FINAL: begin
        if (stat_i.out_free) begin
          cmd_o.emit_final = 1'b1;
          state_d          = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

endmodule

### hdl/ptst_dp.sv
`timescale 1ns / 1ps

module ptst_dp import ptst_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  cmd_t                  cmd_i,
  output stat_t                 stat_o,
  input  logic [SLOT_W-1:0]     slot_i,
  input  logic [DEADLINE_W-1:0] deadline_i,
  input  logic [PERIOD_W-1:0]   rearm_period_i,
  input  logic [DEADLINE_W-1:0] now_time_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic                  fired_o,
  output logic [SLOT_W-1:0]     fired_slot_o,
  output logic [DEADLINE_W-1:0] next_deadline_o,
  output logic                  last_o
);

  logic [NUM_SLOTS-1:0]  valid_q, valid_d;
  logic [IDX_W-1:0]      idx_q, idx_d;
  logic [DEADLINE_W-1:0] now_q, now_d;
  logic [DEADLINE_W-1:0] earliest_q, earliest_d;

  logic                  out_valid_q, out_valid_d;
  logic                  fired_q, fired_d;
  logic [SLOT_W-1:0]     fired_slot_q, fired_slot_d;
  logic [DEADLINE_W-1:0] next_deadline_q, next_deadline_d;
  logic                  last_q, last_d;

  logic                  in_range;
  logic [IDX_W-1:0]      in_idx;
  logic [IDX_W-1:0]      idx_inc;
  entry_t                rd_entry;
  entry_t                wr_entry;
  logic                  we;
  logic [IDX_W-1:0]      waddr;
  logic [IDX_W-1:0]      raddr;
  logic                  hit;
  logic                  one_shot;
  logic [DEADLINE_W:0]   sum;
  logic [DEADLINE_W-1:0] new_deadline;
  logic [DEADLINE_W-1:0] cand;
  logic                  keep;
  logic                  out_free;

  assign in_range = (32'(slot_i) < NUM_SLOTS);
  assign in_idx   = IDX_W'(slot_i);
  assign idx_inc  = idx_q + IDX_W'(1);

  assign hit      = valid_q[idx_q] && (rd_entry.deadline <= now_q);
  assign one_shot = (rd_entry.period == '0);

  // Rearm adds the period to the old deadline and saturates at all ones.
  assign sum          = {1'b0, rd_entry.deadline} + (DEADLINE_W + 1)'(rd_entry.period);
  assign new_deadline = sum[DEADLINE_W] ? DEADLINE_NONE : sum[DEADLINE_W-1:0];

  assign cand = hit ? new_deadline : rd_entry.deadline;
  assign keep = valid_q[idx_q] && !(hit && one_shot);

  assign out_free = !out_valid_q || out_ready_i;

  assign stat_o.hit      = hit;
  assign stat_o.last_idx = (idx_q == IDX_W'(NUM_SLOTS - 1));
  assign stat_o.out_free = out_free;

  always_comb begin
    we       = 1'b0;
    waddr    = idx_q;
    wr_entry = '{deadline: new_deadline, period: rd_entry.period};
    if (cmd_i.arm) begin
      we       = in_range;
      waddr    = in_idx;
      wr_entry = '{deadline: deadline_i, period: rearm_period_i};
    end else if (cmd_i.advance && hit && !one_shot) begin
      we = 1'b1;
    end
  end

  always_comb begin
    if (cmd_i.start) begin
      raddr = '0;
    end else if (cmd_i.advance) begin
      raddr = idx_inc;
    end else begin
      raddr = idx_q;
    end
  end

  always_comb begin
    valid_d    = valid_q;
    idx_d      = idx_q;
    now_d      = now_q;
    earliest_d = earliest_q;
    if (cmd_i.arm && in_range) begin
      valid_d[in_idx] = 1'b1;
    end
    if (cmd_i.cancel && in_range) begin
      valid_d[in_idx] = 1'b0;
    end
    if (cmd_i.start) begin
      idx_d      = '0;
      now_d      = now_time_i;
      earliest_d = DEADLINE_NONE;
    end
    if (cmd_i.advance) begin
      idx_d = idx_inc;
      if (hit && one_shot) begin
        valid_d[idx_q] = 1'b0;
      end
      if (keep && (cand < earliest_q)) begin
        earliest_d = cand;
      end
    end
  end

  always_comb begin
    out_valid_d     = out_valid_q && !out_ready_i;
    fired_d         = fired_q;
    fired_slot_d    = fired_slot_q;
    next_deadline_d = next_deadline_q;
    last_d          = last_q;
    if (cmd_i.emit_fired) begin
      out_valid_d     = 1'b1;
      fired_d         = 1'b1;
      fired_slot_d    = SLOT_W'(idx_q);
      next_deadline_d = '0;
      last_d          = 1'b0;
    end else if (cmd_i.emit_final) begin
      out_valid_d     = 1'b1;
      fired_d         = 1'b0;
      fired_slot_d    = '0;
      next_deadline_d = earliest_q;
      last_d          = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q     <= '0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      valid_q     <= valid_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    now_q           <= now_d;
    earliest_q      <= earliest_d;
    fired_q         <= fired_d;
    fired_slot_q    <= fired_slot_d;
    next_deadline_q <= next_deadline_d;
    last_q          <= last_d;
  end

  ptst_ram #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (NUM_SLOTS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wr_entry),
    .raddr_i (raddr),
    .rdata_o (rd_entry)
  );

  assign out_valid_o     = out_valid_q;
  assign fired_o         = fired_q;
  assign fired_slot_o    = fired_slot_q;
  assign next_deadline_o = next_deadline_q;
  assign last_o          = last_q;

endmodule

### hdl/periodic_timer_slot_table.sv
`timescale 1ns / 1ps
// Arm and cancel transactions give no result.
// A tick scans the slots in order through the single read port of the slot
// store, one slot a cycle unless a hit waits for the output register.
// A fired result passes the registered RAM read and then the output register.
// Reset (rst_ni, asynchronous, active low) clears every valid mark, the
// controller state and the output valid; deadlines and periods are not reset.

module periodic_timer_slot_table import ptst_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,

  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [OP_W-1:0]       op_i,
  input  logic [SLOT_W-1:0]     slot_i,
  input  logic [DEADLINE_W-1:0] deadline_i,
  input  logic [PERIOD_W-1:0]   rearm_period_i,
  input  logic [DEADLINE_W-1:0] now_time_i,

  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic                  fired_o,
  output logic [SLOT_W-1:0]     fired_slot_o,
  output logic [DEADLINE_W-1:0] next_deadline_o,
  output logic                  last_o
);

  // The controller decides, one slot per cycle, whether the datapath moves on
  // or holds; a hit is held until the output register is free. The datapath
  // keeps the valid marks in flip-flops and the deadlines and periods in a
  // small RAM whose registered read is addressed one slot ahead of the scan.

  cmd_t  cmd;
  stat_t stat;

  ptst_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .op_i       (op_i),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  // The output register lets a new transaction enter while the final result
  // of a tick still waits to be taken.
  ptst_dp u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .stat_o          (stat),
    .slot_i          (slot_i),
    .deadline_i      (deadline_i),
    .rearm_period_i  (rearm_period_i),
    .now_time_i      (now_time_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .fired_o         (fired_o),
    .fired_slot_o    (fired_slot_o),
    .next_deadline_o (next_deadline_o),
    .last_o          (last_o)
  );

endmodule
